FILE: hw/rtl/cdns_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte tables for the captive DNS responder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package cdns_pkg;

    localparam int MAX_PACKET = 512;
    localparam int POS_W      = 11;
    localparam int HDR_LEN    = 12;
    localparam int ID_LEN     = 2;
    localparam int TAIL_LEN   = 4;
    localparam int ANS_LEN    = 16;
    localparam int ANS_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_IPV4 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL  = 2'd1;

    localparam logic [31:0] IPV4_RESET = 32'hC0A8_6401;
    localparam logic [31:0] TTL_RESET  = 32'd60;

    typedef enum logic [1:0] {
        END_NONE   = 2'd0,
        END_DROP   = 2'd1,
        END_ANSWER = 2'd2
    } end_kind_t;

    // One queue entry: an optional copied byte, then an optional end action.
    typedef struct packed {
        logic      has_byte;
        logic [7:0] data;
        end_kind_t end_kind;
    } cmd_t;

    // Fixed header bytes at positions 2 to 11: flags 0x8180, one question,
    // one answer, no authority or additional records.
    function automatic logic [7:0] header_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd2:    b = 8'h81;
            4'd3:    b = 8'h80;
            4'd5:    b = 8'h01;
            4'd7:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte idx of the appended A record.
    function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] ipv4);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd3:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd6:    b = ttl[31:24];
            4'd7:    b = ttl[23:16];
            4'd8:    b = ttl[15:8];
            4'd9:    b = ttl[7:0];
            4'd11:   b = 8'h04;
            4'd12:   b = ipv4[31:24];
            4'd13:   b = ipv4[23:16];
            4'd14:   b = ipv4[15:8];
            4'd15:   b = ipv4[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/cdns_front.sv
`timescale 1ns / 1ps
// Front end: tracks the position in the request, walks the question name
// and turns each request byte into at most one queue entry. Uses cdns_pkg.
module cdns_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        req_byte,
    input  logic              req_last,
    output logic              push,
    output cdns_pkg::cmd_t    push_cmd
);

    logic [cdns_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [cdns_pkg::POS_W-1:0] label_pos_reg, label_pos_next;
    logic                       name_ended_reg, name_ended_next;
    logic [2:0]                 tail_reg, tail_next;
    logic                       in_range;
    logic                       fail;
    cdns_pkg::cmd_t             cmd;

    always_comb
    begin
        pos_next        = pos_reg;
        label_pos_next  = label_pos_reg;
        name_ended_next = name_ended_reg;
        tail_next       = tail_reg;
        cmd.has_byte    = 1'b0;
        cmd.data        = req_byte;
        cmd.end_kind    = cdns_pkg::END_NONE;
        in_range        = pos_reg < cdns_pkg::POS_W'(cdns_pkg::MAX_PACKET);

        if (in_range)
        begin
            if (pos_reg < cdns_pkg::POS_W'(cdns_pkg::ID_LEN))
            begin
                cmd.has_byte = 1'b1;
            end
            else if (pos_reg < cdns_pkg::POS_W'(cdns_pkg::HDR_LEN))
            begin
                cmd.has_byte = 1'b1;
                cmd.data     = cdns_pkg::header_byte(pos_reg[3:0]);
            end
            else if (!name_ended_reg)
            begin
                cmd.has_byte = 1'b1;
                if (pos_reg == label_pos_reg)
                begin
                    if (req_byte == 8'd0)
                        name_ended_next = 1'b1;
                    else
                        label_pos_next = label_pos_reg
                                       + cdns_pkg::POS_W'(req_byte)
                                       + cdns_pkg::POS_W'(1);
                end
            end
            else if (tail_reg < 3'(cdns_pkg::TAIL_LEN))
            begin
                cmd.has_byte = 1'b1;
                tail_next    = tail_reg + 3'd1;
            end
            pos_next = pos_reg + cdns_pkg::POS_W'(1);
        end

        // The end decision looks at the state after this byte.
        fail = (pos_next <= cdns_pkg::POS_W'(cdns_pkg::HDR_LEN))
             || !name_ended_next
             || (tail_next < 3'(cdns_pkg::TAIL_LEN))
             || (({1'b0, label_pos_next} + (cdns_pkg::POS_W + 1)'(21))
                 > (cdns_pkg::POS_W + 1)'(cdns_pkg::MAX_PACKET));

        if (req_last)
        begin
            cmd.end_kind    = fail ? cdns_pkg::END_DROP : cdns_pkg::END_ANSWER;
            pos_next        = '0;
            label_pos_next  = cdns_pkg::POS_W'(cdns_pkg::HDR_LEN);
            name_ended_next = 1'b0;
            tail_next       = '0;
        end
    end

    assign push     = accept && (cmd.has_byte || req_last);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            label_pos_reg  <= cdns_pkg::POS_W'(cdns_pkg::HDR_LEN);
            name_ended_reg <= 1'b0;
            tail_reg       <= '0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            label_pos_reg  <= label_pos_next;
            name_ended_reg <= name_ended_next;
            tail_reg       <= tail_next;
        end
    end

endmodule

FILE: hw/rtl/cdns_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Uses cdns_pkg for the entry type and depth.
module cdns_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cdns_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cdns_pkg::cmd_t head
);

    cdns_pkg::cmd_t                 entries_reg [cdns_pkg::QDEPTH];
    logic [cdns_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cdns_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cdns_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign full      = count_reg == cdns_pkg::QCNT_W'(cdns_pkg::QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + cdns_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + cdns_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + cdns_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - cdns_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/cdns_back.sv
`timescale 1ns / 1ps
// Back end: executes queue entries, sending copied bytes, drop markers and
// the 16-byte answer through a registered output. Uses cdns_pkg.
module cdns_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  cdns_pkg::cmd_t q_head,
    output logic           q_pop,
    input  logic [31:0]    answer_ipv4,
    input  logic [31:0]    answer_ttl,
    output logic           resp_valid,
    input  logic           resp_stall,
    output logic [7:0]     resp_byte,
    output logic           resp_last,
    output logic           drop
);

    logic                              has_byte_reg, has_byte_next;
    cdns_pkg::end_kind_t               end_reg, end_next;
    logic [7:0]                        data_reg, data_next;
    logic [cdns_pkg::ANS_IDX_W-1:0]    idx_reg, idx_next;
    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        out_byte_reg, out_byte_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_drop_reg, out_drop_next;
    logic                              out_free, busy, emit, finishing;

    assign out_free = !out_valid_reg || !resp_stall;
    assign busy     = has_byte_reg || (end_reg != cdns_pkg::END_NONE);
    assign emit     = out_free && busy;

    always_comb
    begin
        has_byte_next  = has_byte_reg;
        end_next       = end_reg;
        data_next      = data_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && resp_stall;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        finishing      = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (has_byte_reg)
            begin
                out_byte_next = data_reg;
                out_last_next = 1'b0;
                out_drop_next = 1'b0;
                has_byte_next = 1'b0;
                finishing     = end_reg == cdns_pkg::END_NONE;
            end
            else if (end_reg == cdns_pkg::END_DROP)
            begin
                out_byte_next = 8'd0;
                out_last_next = 1'b1;
                out_drop_next = 1'b1;
                end_next      = cdns_pkg::END_NONE;
                finishing     = 1'b1;
            end
            else
            begin
                out_byte_next = cdns_pkg::answer_byte(idx_reg, answer_ttl, answer_ipv4);
                out_last_next = &idx_reg;
                out_drop_next = 1'b0;
                idx_next      = idx_reg + cdns_pkg::ANS_IDX_W'(1);
                if (&idx_reg)
                begin
                    end_next  = cdns_pkg::END_NONE;
                    finishing = 1'b1;
                end
            end
        end

        q_pop = q_not_empty && (!busy || finishing);
        if (q_pop)
        begin
            has_byte_next = q_head.has_byte;
            data_next     = q_head.data;
            end_next      = q_head.end_kind;
            idx_next      = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_byte_reg  <= 1'b0;
            end_reg       <= cdns_pkg::END_NONE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            has_byte_reg  <= has_byte_next;
            end_reg       <= end_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign resp_valid = out_valid_reg;
    assign resp_byte  = out_byte_reg;
    assign resp_last  = out_last_reg;
    assign drop       = out_drop_reg;

endmodule

FILE: hw/rtl/captive_dns_responder_unit.sv
`timescale 1ns / 1ps
// Top level of the captive DNS responder: configuration registers plus the
// front end, command queue and back end. Uses cdns_pkg and the cdns_* modules.

// The block accepts one request byte per cycle and answers every DNS query
// with a single A record. The front end takes a byte in every cycle in which
// req_valid is high and the four-entry command queue has room; req_stall
// rises only when that queue is full. Each request byte yields at most one
// response item, so ordinary bytes pass through at one per cycle while
// resp_stall is low. The final byte of a request also starts either a
// one-item drop marker or the 16-byte answer record; the back end sends those
// at one item per cycle while resp_stall is low, and the front end keeps
// taking the next request's bytes until the queue fills. A drop marker
// (resp_byte 0, resp_last 1, drop 1) means every byte already sent for that
// request must be discarded. The address and TTL registers are written
// through the cfg port, which is always ready; they should be changed only
// while no request is in flight.
module captive_dns_responder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [7:0]                        req_byte,
    input  logic                              req_last,
    output logic                              resp_valid,
    input  logic                              resp_stall,
    output logic [7:0]                        resp_byte,
    output logic                              resp_last,
    output logic                              drop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic [31:0]    ipv4_reg, ttl_reg;
    logic           accept;
    logic           push;
    cdns_pkg::cmd_t push_cmd;
    logic           q_full, q_not_empty, q_pop;
    cdns_pkg::cmd_t q_head;

    // Writes to an index past the two registers are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_reg <= cdns_pkg::IPV4_RESET;
            ttl_reg  <= cdns_pkg::TTL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cdns_pkg::CFG_ANSWER_IPV4: ipv4_reg <= cfg_data;
                cdns_pkg::CFG_ANSWER_TTL:  ttl_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // The front end never needs more than one queue slot per byte, so a full
    // queue is the only reason to hold off the request side.
    assign req_stall = q_full;
    assign accept    = req_valid && !req_stall;

    cdns_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_byte (req_byte),
        .req_last (req_last),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cdns_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cdns_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .answer_ipv4 (ipv4_reg),
        .answer_ttl  (ttl_reg),
        .resp_valid  (resp_valid),
        .resp_stall  (resp_stall),
        .resp_byte   (resp_byte),
        .resp_last   (resp_last),
        .drop        (drop)
    );

endmodule

FILE: hw/rtl/cdns_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the captive DNS responder, bound to the top level.
// Depends only on the top level's ports.
module cdns_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_stall,
    input logic                           resp_valid,
    input logic                           resp_stall,
    input logic [7:0]                     resp_byte,
    input logic                           resp_last,
    input logic                           drop,
    input logic                           cfg_ready
);

    // A drop marker is always a single closing item.
    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && drop |-> resp_last)
        else $error("drop marker without resp_last");

    // A drop marker carries a zero byte.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && drop |-> resp_byte == 8'd0)
        else $error("drop marker with nonzero byte");

    // A stalled response item holds.
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_stall |=> resp_valid && $stable(resp_byte)
                                     && $stable(resp_last) && $stable(drop))
        else $error("stalled response item changed");

    // The request stall is always a known level once out of reset.
    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(req_stall))
        else $error("req_stall is unknown");

    // The configuration port never holds off a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready dropped");

endmodule

bind captive_dns_responder_unit cdns_checker u_cdns_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_stall  (req_stall),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp_byte  (resp_byte),
    .resp_last  (resp_last),
    .drop       (drop),
    .cfg_ready  (cfg_ready)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for captive_dns_responder_unit: directed and random DNS requests
// are checked byte for byte against a built-in response predictor. Depends on cdns_pkg.
module tb_top;

    // Spare register indexes; writes to them must leave both answer registers alone.
    localparam logic [cdns_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [cdns_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Header bytes 0 to 11 of every response; the two identifier bytes are echoed instead.
    localparam logic [95:0] FIXED_HDR = 96'h0000_8180_0001_0001_0000_0000;

    localparam int RANDOM_FILL   = -1;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int PHASE_ITEMS   = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } resp_item_t;

    typedef enum {REQ_QUERY, REQ_SHORT, REQ_CUT, REQ_NOISE} req_kind_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    logic [7:0]                     req_byte = 8'h00;
    logic                           req_last = 1'b0;
    logic                           resp_valid;
    logic                           resp_stall = 1'b0;
    logic [7:0]                     resp_byte;
    logic                           resp_last;
    logic                           drop;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cdns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data = '0;

    // Predictor copy of the per-request walk and of the two answer registers.
    logic [10:0] req_pos = 11'd0;
    logic [10:0] label_pos = 11'd12;
    logic        name_done = 1'b0;
    logic [2:0]  tail_cnt = 3'd0;
    logic [31:0] ipv4_reg = cdns_pkg::IPV4_RESET;
    logic [31:0] ttl_reg = cdns_pkg::TTL_RESET;

    resp_item_t  pending_resp_q[$];
    logic [7:0]  req_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int err_count = 0;
    int req_items = 0;
    int resp_items = 0;
    int requests_sent = 0;
    int answers_seen = 0;
    int drops_seen = 0;

    captive_dns_responder_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_byte   (req_byte),
        .req_last   (req_last),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp_byte  (resp_byte),
        .resp_last  (resp_last),
        .drop       (drop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // Safety net: the slowest legal run finishes far earlier than this.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response predictor
    // ------------------------------------------------------------------

    function automatic void push_resp(input logic [7:0] d, input logic l, input logic dr);
        resp_item_t item;
        item.data = d;
        item.last = l;
        item.drop = dr;
        pending_resp_q.push_back(item);
    endfunction

    function automatic void clear_request_walk();
        req_pos = 11'd0;
        label_pos = 11'd12;
        name_done = 1'b0;
        tail_cnt = 3'd0;
    endfunction

    function automatic void apply_reg_write(input logic [cdns_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [31:0] value);
        if (idx == cdns_pkg::CFG_ANSWER_IPV4)
            ipv4_reg = value;
        else if (idx == cdns_pkg::CFG_ANSWER_TTL)
            ttl_reg = value;
    endfunction

    // Works out the response items that one accepted request byte causes.
    function automatic void predict_response(input logic [7:0] b, input logic last);
        logic [127:0] record;
        int p;
        int resp_len;
        p = int'(req_pos);
        // Bytes at or beyond the packet limit are neither copied nor walked.
        if (p < cdns_pkg::MAX_PACKET)
        begin
            if (p < cdns_pkg::ID_LEN)
                push_resp(b, 1'b0, 1'b0);
            else if (p < cdns_pkg::HDR_LEN)
                push_resp(FIXED_HDR[95 - 8 * p -: 8], 1'b0, 1'b0);
            else if (!name_done)
            begin
                // Every byte at a label boundary is taken as a plain length, even 0xC0.
                push_resp(b, 1'b0, 1'b0);
                if (req_pos == label_pos)
                begin
                    if (b == 8'd0)
                        name_done = 1'b1;
                    else
                        label_pos = label_pos + 11'(b) + 11'd1;
                end
            end
            else if (int'(tail_cnt) < cdns_pkg::TAIL_LEN)
            begin
                push_resp(b, 1'b0, 1'b0);
                tail_cnt++;
            end
            req_pos = req_pos + 11'd1;
        end
        if (last)
        begin
            // Header, question up to and including type and class, then the answer.
            resp_len = cdns_pkg::HDR_LEN
                     + (int'(label_pos) - cdns_pkg::HDR_LEN + 1 + cdns_pkg::TAIL_LEN)
                     + cdns_pkg::ANS_LEN;
            if (int'(req_pos) <= cdns_pkg::HDR_LEN || !name_done ||
                int'(tail_cnt) < cdns_pkg::TAIL_LEN || resp_len > cdns_pkg::MAX_PACKET)
                push_resp(8'h00, 1'b1, 1'b1);
            else
            begin
                record = {16'hC00C, 16'h0001, 16'h0001, ttl_reg, 16'h0004, ipv4_reg};
                for (int i = 0; i < cdns_pkg::ANS_LEN; i++)
                    push_resp(record[127 - 8 * i -: 8], i == cdns_pkg::ANS_LEN - 1, 1'b0);
            end
            clear_request_walk();
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register writes and request bytes feed the predictor, response items are
    // checked against the oldest prediction. One process, so order within an edge is fixed.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : resp_monitor
        resp_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (req_valid && !req_stall)
            begin
                predict_response(req_byte, req_last);
                req_items++;
            end
            if (resp_valid && !resp_stall)
            begin
                resp_items++;
                if (drop)
                    drops_seen++;
                else if (resp_last)
                    answers_seen++;
                if (pending_resp_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("%0t: unexpected response item: byte %02h last %0b drop %0b",
                                 $realtime, resp_byte, resp_last, drop);
                    err_count++;
                end
                else
                begin
                    want = pending_resp_q.pop_front();
                    if (want.data !== resp_byte || want.last !== resp_last ||
                        want.drop !== drop)
                    begin
                        if (err_count < 10)
                            $display({"%0t: response item %0d: expected byte %02h last %0b ",
                                      "drop %0b, got byte %02h last %0b drop %0b"},
                                     $realtime, resp_items, want.data, want.last, want.drop,
                                     resp_byte, resp_last, drop);
                        err_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            resp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            resp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            resp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_byte <= b;
        req_last <= last;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Sends the request built in req_buf; valid stays high so requests can run back to back.
    task automatic send_request();
        for (int i = 0; i < req_buf.size(); i++)
            send_item(req_buf[i], i == req_buf.size() - 1);
        req_buf.delete();
        requests_sent++;
    endtask

    task automatic add_bytes(input int n, input int fill);
        logic [7:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            req_buf.push_back(v);
        end
    endtask

    task automatic add_label(input int len, input int fill);
        req_buf.push_back(8'(len));
        add_bytes(len, fill);
    endtask

    // Question name terminator followed by four type and class bytes.
    task automatic add_name_end();
        req_buf.push_back(8'h00);
        add_bytes(cdns_pkg::TAIL_LEN, RANDOM_FILL);
    endtask

    // Stops offering items, waits for every predicted item, then lets the block go quiet,
    // since bytes after a question leave nothing to wait for.
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (pending_resp_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [cdns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic build_random_request();
        req_kind_t kind;
        int pick;
        int keep;
        pick = $urandom_range(99);
        kind = (pick < 72) ? REQ_QUERY : (pick < 82) ? REQ_SHORT :
               (pick < 92) ? REQ_CUT : REQ_NOISE;
        case (kind)
            REQ_SHORT:
                add_bytes($urandom_range(1, cdns_pkg::HDR_LEN), RANDOM_FILL);
            REQ_NOISE:
                add_bytes($urandom_range(cdns_pkg::HDR_LEN + 1, 40), RANDOM_FILL);
            default:
            begin
                add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
                repeat ($urandom_range(0, 3))
                    add_label($urandom_range(1, 12), RANDOM_FILL);
                add_name_end();
                if (kind == REQ_QUERY && $urandom_range(3) == 0)
                    add_bytes($urandom_range(1, 6), RANDOM_FILL);
                if (kind == REQ_CUT)
                begin
                    // Cut somewhere inside the question so that it runs past the end.
                    keep = $urandom_range(cdns_pkg::HDR_LEN + 1, req_buf.size() - 1);
                    while (req_buf.size() > keep)
                        void'(req_buf.pop_back());
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Requests that must end in a drop marker because the question is incomplete.
    task automatic test_short_requests();
        add_bytes(1, RANDOM_FILL);
        send_request();
        add_bytes(cdns_pkg::HDR_LEN, 8'hFF);
        send_request();
        // Root name terminator only, no type or class.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        req_buf.push_back(8'h00);
        send_request();
        // Three of the four type and class bytes.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        req_buf.push_back(8'h00);
        add_bytes(cdns_pkg::TAIL_LEN - 1, RANDOM_FILL);
        send_request();
        // Name without a terminator.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(5, RANDOM_FILL);
        send_request();
        drain_and_settle();
    endtask

    // Well-formed queries answered with the reset-time address and TTL.
    task automatic test_basic_queries();
        // Smallest legal query: root name, all-ones identifier.
        add_bytes(cdns_pkg::ID_LEN, 8'hFF);
        add_bytes(cdns_pkg::HDR_LEN - cdns_pkg::ID_LEN, 8'h00);
        add_name_end();
        send_request();
        add_bytes(cdns_pkg::ID_LEN, 8'h00);
        add_bytes(cdns_pkg::HDR_LEN - cdns_pkg::ID_LEN, 8'hFF);
        add_label(63, 8'hFF);
        add_label(1, 8'h00);
        add_name_end();
        send_request();
        // Trailing bytes after the question are ignored.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(7, RANDOM_FILL);
        add_name_end();
        add_bytes(9, RANDOM_FILL);
        send_request();
        // A compression pointer byte is still walked as a length of 192.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(8'hC0, RANDOM_FILL);
        add_name_end();
        send_request();
        drain_and_settle();
    endtask

    // Responses right at and just over the packet limit, and requests longer than it.
    task automatic test_size_limits();
        // Terminator at position 491: the response is exactly MAX_PACKET bytes.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        repeat (7) add_label(63, RANDOM_FILL);
        add_label(30, RANDOM_FILL);
        add_name_end();
        send_request();
        // One byte more and the response is too big.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        repeat (7) add_label(63, RANDOM_FILL);
        add_label(31, RANDOM_FILL);
        add_name_end();
        send_request();
        // Name runs past the limit, so its terminator is never seen.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        repeat (8) add_label(63, RANDOM_FILL);
        add_name_end();
        send_request();
        // Short question, then padding so that the final byte lies past the limit.
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(5, RANDOM_FILL);
        add_name_end();
        add_bytes(600 - req_buf.size(), RANDOM_FILL);
        send_request();
        drain_and_settle();
    endtask

    // Register extremes, and writes to the spare indexes that must change nothing.
    task automatic test_answer_registers();
        write_reg(cdns_pkg::CFG_ANSWER_IPV4, 32'h0000_0000);
        write_reg(cdns_pkg::CFG_ANSWER_TTL, 32'h0000_0000);
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(3, RANDOM_FILL);
        add_name_end();
        send_request();
        drain_and_settle();
        write_reg(cdns_pkg::CFG_ANSWER_IPV4, 32'hFFFF_FFFF);
        write_reg(cdns_pkg::CFG_ANSWER_TTL, 32'hFFFF_FFFF);
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_name_end();
        send_request();
        drain_and_settle();
        write_reg(cdns_pkg::CFG_ANSWER_IPV4, 32'hA5C3_3C5A);
        write_reg(cdns_pkg::CFG_ANSWER_TTL, 32'h5A3C_C3A5);
        write_reg(CFG_SPARE_2, $urandom());
        write_reg(CFG_SPARE_3, $urandom());
        add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
        add_label(2, RANDOM_FILL);
        add_name_end();
        send_request();
        drain_and_settle();
    endtask

    // Random requests under one mix of sender gaps and receiver stalls.
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int first;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(cdns_pkg::CFG_ANSWER_IPV4, $urandom());
        write_reg(cdns_pkg::CFG_ANSWER_TTL, $urandom());
        first = req_items;
        while (req_items - first < PHASE_ITEMS)
        begin
            build_random_request();
            send_request();
        end
        drain_and_settle();
    endtask

    // The receiver holds off for a long stretch while queries keep coming, so the
    // command queue fills and the block has to stall its input.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_OFF_LEN;
        @(negedge clk);
        repeat (3)
        begin
            add_bytes(cdns_pkg::HDR_LEN, RANDOM_FILL);
            add_label($urandom_range(1, 12), RANDOM_FILL);
            add_name_end();
            send_request();
        end
        drain_and_settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_requests();
        test_basic_queries();
        test_size_limits();
        test_answer_registers();
        test_random_phase(0, 0);
        test_random_phase(56, 0);
        test_random_phase(0, 56);
        test_random_phase(21, 21);
        test_output_hold_off();

        if (pending_resp_q.size() != 0)
        begin
            if (err_count < 10)
                $display("%0d predicted response items never arrived", pending_resp_q.size());
            err_count += pending_resp_q.size();
        end
        $display("Ran %0d requests (%0d bytes in, %0d bytes out): %0d answers, %0d drops,",
                 requests_sent, req_items, resp_items, answers_seen, drops_seen);
        $display("over four gap and stall mixes, size limits and a long output hold-off.");
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
